/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("closest pair check failed");

// Next-cycle implication
`define CPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("closest pair check failed");

`endif

/* rtl/cpd_pkg.sv */
// ----------------------------------------------------------------------------
// cpd_pkg
// Types and fixed constants shared by the closest pair distance block.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Port field widths
    localparam int COORD_IN_W  = 16;
    localparam int OUT_SQ_W    = 33;
    localparam int OUT_FIX_W   = 25;

    // Square root unit: radicand is the clamped distance shifted by 16
    localparam int SQRT_RAD_W  = 64;
    localparam int SQRT_RES_W  = 32;
    localparam int SQRT_CNT_W  = 5;
    localparam int FIX_SHIFT   = 16;
    localparam int CLAMP_BITS  = 47;
    localparam logic [SQRT_RAD_W-1:0] SQ_CLAMP = (64'd1 << CLAMP_BITS) - 64'd1;

    // Status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* rtl/closest_pair_distance_core.sv */
// A point is stored in the cycle it is accepted, one point per cycle.
// After the last point the pair scan of n >= 2 points runs, paced by the single
// read port of the point store, then the square root, and the result is registered.
// Points are stalled during scan and root, and while a finished result waits
// behind one that has not been taken yet.
// Reset clears count, flags and handshakes; the point store is not cleared.
// ----------------------------------------------------------------------------
// closest_pair_distance_core
// Closest pair of 2-D points: load a point set, report the minimum squared
// distance and its square root in fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module closest_pair_distance_core import cpd_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pt_valid,
    output logic                        pt_stall,
    input  logic signed [COORD_IN_W-1:0] x_coord,
    input  logic signed [COORD_IN_W-1:0] y_coord,
    input  logic                        last_point,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [OUT_SQ_W-1:0]         min_sq_distance,
    output logic [OUT_FIX_W-1:0]        min_distance_fixed,
    output logic                        no_pair,
    output logic                        dropped_points
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int DW   = 2 * COORD_BITS;
    localparam int SQW  = 2 * COORD_BITS + 1;

    typedef enum logic [1:0] {ST_LOAD, ST_SEARCH, ST_SQRT, ST_HOLD} st_t;

    st_t                   state_reg;
    logic [CNTW-1:0]       count_reg;
    logic                  ovf_reg;
    logic [CNTW-1:0]       n_reg;
    logic                  set_ovf_reg;
    logic                  srch_start_reg;
    logic                  sqrt_start_reg;
    logic                  res_valid_reg;
    logic [OUT_SQ_W-1:0]   min_sq_reg;
    logic [OUT_FIX_W-1:0]  min_fix_reg;
    logic                  no_pair_reg;
    logic                  dropped_reg;

    logic                  pt_accept;
    logic                  store_full;
    logic                  mem_we;
    logic signed [COORD_BITS-1:0] x_pt;
    logic signed [COORD_BITS-1:0] y_pt;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic [SQW-1:0]        best;
    logic [SQRT_RAD_W-1:0] best_ext;
    logic [SQRT_RAD_W-1:0] best_clamp;
    logic [SQRT_RAD_W-1:0] radicand;
    logic [SQRT_RES_W-1:0] root;
    logic                  set_no_pair;
    logic                  out_load;
    unit_stat_t            srch_stat;
    unit_stat_t            sqrt_stat;

    // Input transaction and store write
    assign pt_stall   = (state_reg != ST_LOAD);
    assign pt_accept  = pt_valid && !pt_stall;
    assign store_full = (count_reg == CNTW'(MAX_POINTS));
    assign mem_we     = pt_accept && !store_full;
    assign x_pt       = COORD_BITS'($unsigned(x_coord));
    assign y_pt       = COORD_BITS'($unsigned(y_coord));

    cpd_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({x_pt, y_pt}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cpd_pair_search #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW),
        .CNTW       (CNTW)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (srch_start_reg),
        .n_points (n_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .best     (best),
        .stat     (srch_stat)
    );

    // Clamp the best distance and scale by 2^16 for 8 fraction bits of root
    assign best_ext   = SQRT_RAD_W'(best);
    assign best_clamp = (best_ext > SQ_CLAMP) ? SQ_CLAMP : best_ext;
    assign radicand   = {best_clamp[SQRT_RAD_W-FIX_SHIFT-1:0], FIX_SHIFT'(0)};

    cpd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (radicand),
        .root     (root),
        .stat     (sqrt_stat)
    );

    assign set_no_pair = (n_reg < CNTW'(2));
    assign out_load    = (state_reg == ST_HOLD) && (!res_valid_reg || !res_stall);

    // Control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            n_reg          <= '0;
            set_ovf_reg    <= 1'b0;
            srch_start_reg <= 1'b0;
            sqrt_start_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            min_sq_reg     <= '0;
            min_fix_reg    <= '0;
            no_pair_reg    <= 1'b0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            srch_start_reg <= 1'b0;
            sqrt_start_reg <= 1'b0;
            // Drop the result once taken, unless a new one replaces it
            if (res_valid_reg && !res_stall && !out_load)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (pt_accept)
                    begin
                        if (last_point)
                        begin
                            n_reg          <= store_full ? count_reg
                                                         : count_reg + CNTW'(1);
                            set_ovf_reg    <= ovf_reg || store_full;
                            count_reg      <= '0;
                            ovf_reg        <= 1'b0;
                            srch_start_reg <= 1'b1;
                            state_reg      <= ST_SEARCH;
                        end
                        else if (store_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CNTW'(1);
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (srch_stat.done)
                    begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sqrt_stat.done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_load)
                    begin
                        res_valid_reg <= 1'b1;
                        min_sq_reg    <= set_no_pair ? '0 : best_ext[OUT_SQ_W-1:0];
                        min_fix_reg   <= set_no_pair ? '0 : root[OUT_FIX_W-1:0];
                        no_pair_reg   <= set_no_pair;
                        dropped_reg   <= set_ovf_reg;
                        state_reg     <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign res_valid          = res_valid_reg;
    assign min_sq_distance    = min_sq_reg;
    assign min_distance_fixed = min_fix_reg;
    assign no_pair            = no_pair_reg;
    assign dropped_points     = dropped_reg;

    `CPD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNTW'(MAX_POINTS))
    `CPD_ASSERT_NEXT(a_last_starts, pt_accept && last_point, state_reg == ST_SEARCH && srch_start_reg)
    `CPD_ASSERT_IMP(a_srch_done_state, srch_stat.done, state_reg == ST_SEARCH)
    `CPD_ASSERT_IMP(a_sqrt_done_state, sqrt_stat.done, state_reg == ST_SQRT)
    `CPD_ASSERT_IMP(a_load_units_idle, state_reg == ST_LOAD, !srch_stat.busy && !sqrt_stat.busy)

endmodule

/* rtl/cpd_point_mem.sv */
// ----------------------------------------------------------------------------
// cpd_point_mem
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cpd_point_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cpd_pair_search.sv */
// ----------------------------------------------------------------------------
// cpd_pair_search
// Brute-force pair scan over the point store: latch a pivot point, stream
// every later point past it, and keep the smallest squared distance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpd_pair_search import cpd_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int AW         = 10,
    parameter int CNTW       = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CNTW-1:0]         n_points,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    input  logic [2*COORD_BITS-1:0] rd_data,
    output logic [2*COORD_BITS:0]   best,
    output unit_stat_t              stat
);

    localparam int C   = COORD_BITS;
    localparam int SQW = 2 * COORD_BITS + 1;

    typedef enum logic [1:0] {E_IDLE, E_PIVOT, E_SCAN, E_DRAIN} eng_st_t;

    eng_st_t              state_reg;
    logic [AW-1:0]        i_reg;
    logic [AW-1:0]        j_reg;
    logic [CNTW-1:0]      n_reg;
    logic                 pivot_ld_reg;
    logic                 pair_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 done_reg;
    logic [2*C-1:0]       pivot_reg;
    logic [C-1:0]         dx_reg;
    logic [C-1:0]         dy_reg;
    logic [2*C-1:0]       sqx_reg;
    logic [2*C-1:0]       sqy_reg;
    logic [SQW-1:0]       best_reg;

    logic                 j_last;
    logic                 row_last;
    logic signed [C-1:0]  px;
    logic signed [C-1:0]  py;
    logic signed [C-1:0]  qx;
    logic signed [C-1:0]  qy;
    logic signed [C:0]    diff_x;
    logic signed [C:0]    diff_y;
    logic [C:0]           abs_x;
    logic [C:0]           abs_y;
    logic [SQW-1:0]       sum_sq;

    // Scan bounds
    assign j_last   = (CNTW'(j_reg) + CNTW'(1)) == n_reg;
    assign row_last = (CNTW'(i_reg) + CNTW'(2)) >= n_reg;

    // Read request
    assign rd_en   = (state_reg == E_PIVOT) || (state_reg == E_SCAN);
    assign rd_addr = (state_reg == E_PIVOT) ? i_reg : j_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= E_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            pivot_ld_reg <= 1'b0;
            pair_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pivot_ld_reg <= (state_reg == E_PIVOT);
            pair_reg     <= (state_reg == E_SCAN);
            done_reg     <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= n_points;
                        i_reg <= '0;
                        state_reg <= (n_points < CNTW'(2)) ? E_DRAIN : E_PIVOT;
                    end
                end
                E_PIVOT:
                begin
                    j_reg     <= i_reg + AW'(1);
                    state_reg <= E_SCAN;
                end
                E_SCAN:
                begin
                    if (j_last)
                    begin
                        if (row_last)
                        begin
                            state_reg <= E_DRAIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= E_PIVOT;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                E_DRAIN:
                begin
                    if (!pair_reg && !v1_reg && !v2_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    // Absolute coordinate differences against the pivot
    assign px     = pivot_reg[2*C-1:C];
    assign py     = pivot_reg[C-1:0];
    assign qx     = rd_data[2*C-1:C];
    assign qy     = rd_data[C-1:0];
    assign diff_x = (C+1)'(qx) - (C+1)'(px);
    assign diff_y = (C+1)'(qy) - (C+1)'(py);
    assign abs_x  = diff_x[C] ? (C+1)'(-diff_x) : (C+1)'(diff_x);
    assign abs_y  = diff_y[C] ? (C+1)'(-diff_y) : (C+1)'(diff_y);
    assign sum_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Pipeline valid flags and best distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            best_reg <= '1;
        end
        else
        begin
            v1_reg <= pair_reg;
            v2_reg <= v1_reg;
            if (start && (state_reg == E_IDLE))
            begin
                best_reg <= '1;
            end
            else if (v2_reg && (sum_sq < best_reg))
            begin
                best_reg <= sum_sq;
            end
        end
    end

    // Datapath: pivot, differences, squares
    always_ff @(posedge clk)
    begin
        if (pivot_ld_reg)
        begin
            pivot_reg <= rd_data;
        end
        dx_reg  <= abs_x[C-1:0];
        dy_reg  <= abs_y[C-1:0];
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
    end

    assign best      = best_reg;
    assign stat.busy = (state_reg != E_IDLE);
    assign stat.done = done_reg;

    `CPD_ASSERT_IMP(a_scan_order, state_reg == E_SCAN, j_reg > i_reg)
    `CPD_ASSERT_IMP(a_scan_range, state_reg == E_SCAN, CNTW'(j_reg) < n_reg)
    `CPD_ASSERT_NEXT(a_best_mono, !start, best_reg <= $past(best_reg))

endmodule

/* rtl/cpd_sqrt.sv */
// ----------------------------------------------------------------------------
// cpd_sqrt
// Integer square root, digit by digit, one result bit per cycle.
// ----------------------------------------------------------------------------
module cpd_sqrt import cpd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SQRT_RAD_W-1:0] radicand,
    output logic [SQRT_RES_W-1:0] root,
    output unit_stat_t            stat
);

    localparam int REM_W = SQRT_RES_W + 2;

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [SQRT_RAD_W-1:0] rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SQRT_RES_W-1:0] root_reg;

    logic [REM_W+1:0]      rem_shift;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      rem_sub;
    logic                  fits;

    // Trial subtract of the next bit pair
    assign rem_shift = {rem_reg, rad_reg[SQRT_RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = rem_shift >= trial;
    assign rem_sub   = rem_shift - trial;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + SQRT_CNT_W'(1);
                if (cnt_reg == SQRT_CNT_W'(SQRT_RES_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQRT_RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_reg <= {root_reg[SQRT_RES_W-2:0], fits};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* dv/closest_pair_distance_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_distance_checker
// Watches the point and result channels of the closest pair block, keeps its
// own copy of the current point set, predicts the result that each closing
// point causes and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module closest_pair_distance_checker import cpd_pkg::*; #(
    parameter int MAX_PTS  = 1024,
    parameter int CRD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pt_valid,
    input  logic                         pt_stall,
    input  logic signed [COORD_IN_W-1:0] x_coord,
    input  logic signed [COORD_IN_W-1:0] y_coord,
    input  logic                         last_point,
    input  logic                         res_valid,
    input  logic                         res_stall,
    input  logic [OUT_SQ_W-1:0]          min_sq_distance,
    input  logic [OUT_FIX_W-1:0]         min_distance_fixed,
    input  logic                         no_pair,
    input  logic                         dropped_points,
    output int                           fail_count,
    output int                           pending_count,
    output int                           result_count,
    output int                           lone_sets,
    output int                           overflow_sets
);

    localparam logic [63:0] ROOT_CLAMP = (64'd1 << 47) - 64'd1;
    localparam int          FRAC_SHIFT = 16;

    typedef struct packed {
        logic [OUT_SQ_W-1:0]  sq_dist;
        logic [OUT_FIX_W-1:0] dist_fix;
        logic                 lone;
        logic                 dropped;
    } pair_result_t;

    longint       set_x [MAX_PTS];
    longint       set_y [MAX_PTS];
    int           stored_n;
    bit           overflowed;
    pair_result_t want;
    pair_result_t closest_q [$];

    // Keep the low CRD_BITS bits of a field and sign-extend them
    function automatic longint to_coord(input logic [COORD_IN_W-1:0] raw);
        logic [63:0] u;
        u = 64'(raw) & ((64'd1 << CRD_BITS) - 64'd1);
        if (u[CRD_BITS-1])
            u = u - (64'd1 << CRD_BITS);
        return longint'(u);
    endfunction

    // Squared distance of two points, saturating past 64 bits
    function automatic logic [63:0] pair_dist_sq(input longint ax, input longint ay,
                                                 input longint bx, input longint by);
        logic [63:0] dx;
        logic [63:0] dy;
        logic [64:0] total;
        dx = (ax >= bx) ? 64'(ax - bx) : 64'(bx - ax);
        dy = (ay >= by) ? 64'(ay - by) : 64'(by - ay);
        total = {1'b0, dx * dx} + {1'b0, dy * dy};
        return total[64] ? '1 : total[63:0];
    endfunction

    // Floor of the square root, one result bit per step from the top
    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        int          b;
        r = '0;
        for (b = 31; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    // Scan all pairs of the stored set and build the expected result
    function automatic pair_result_t closest_pair_of_set();
        pair_result_t res;
        logic [63:0]  best;
        logic [63:0]  d;
        logic [31:0]  root;
        int           i;
        int           j;
        best = '1;
        for (i = 0; i < stored_n; i++)
            for (j = i + 1; j < stored_n; j++)
            begin
                d = pair_dist_sq(set_x[i], set_y[i], set_x[j], set_y[j]);
                if (d < best)
                    best = d;
            end
        if (stored_n < 2)
        begin
            res.sq_dist  = '0;
            res.dist_fix = '0;
            res.lone     = 1'b1;
        end
        else
        begin
            d = (best > ROOT_CLAMP) ? ROOT_CLAMP : best;
            root = floor_root(d << FRAC_SHIFT);
            res.sq_dist  = best[OUT_SQ_W-1:0];
            res.dist_fix = root[OUT_FIX_W-1:0];
            res.lone     = 1'b0;
        end
        res.dropped = overflowed;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_n   = 0;
            overflowed = 1'b0;
            closest_q.delete();
        end
        else
        begin
            // Compare each result transaction with the oldest expectation
            if (res_valid && !res_stall)
            begin
                if (closest_q.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = closest_q.pop_front();
                    result_count++;
                    if (min_sq_distance !== want.sq_dist)
                    begin
                        $error("min_sq_distance: expected %0d, got %0d",
                               want.sq_dist, min_sq_distance);
                        fail_count++;
                    end
                    if (min_distance_fixed !== want.dist_fix)
                    begin
                        $error("min_distance_fixed: expected %0d, got %0d",
                               want.dist_fix, min_distance_fixed);
                        fail_count++;
                    end
                    if (no_pair !== want.lone)
                    begin
                        $error("no_pair: expected %0d, got %0d", want.lone, no_pair);
                        fail_count++;
                    end
                    if (dropped_points !== want.dropped)
                    begin
                        $error("dropped_points: expected %0d, got %0d",
                               want.dropped, dropped_points);
                        fail_count++;
                    end
                end
            end

            // Store the point, or drop it and flag the set when the store is full
            if (pt_valid && !pt_stall)
            begin
                if (stored_n < MAX_PTS)
                begin
                    set_x[stored_n] = to_coord(x_coord);
                    set_y[stored_n] = to_coord(y_coord);
                    stored_n++;
                end
                else
                    overflowed = 1'b1;

                // Close the set: predict, then clear for the next one
                if (last_point)
                begin
                    want = closest_pair_of_set();
                    closest_q = {closest_q, want};
                    if (want.lone)
                        lone_sets++;
                    if (want.dropped)
                        overflow_sets++;
                    stored_n   = 0;
                    overflowed = 1'b0;
                end
            end
        end
        pending_count = closest_q.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives point sets into the closest pair block: a few hand-picked sets for
// the coordinate extremes, single points and exact repeats, then random sets
// of varied layout and size with one set that overruns the point store.
// Both channels idle at random; results are checked by the pair checker.
// ----------------------------------------------------------------------------
module tb;
    import cpd_pkg::*;

    localparam int     MAX_PTS         = 1024;
    localparam int     CRD_BITS        = 16;
    localparam int     ITEM_GOAL       = 1600;
    localparam longint CYCLE_LIMIT     = 3_000_000;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     HOLD_OFF_AFTER  = 12;
    localparam int     TAIL_CYCLES     = 100;

    typedef enum int {LAYOUT_SPREAD, LAYOUT_CLUSTER, LAYOUT_ECHO} layout_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                         clk;
    logic                         rst_n;
    logic                         pt_valid;
    logic                         pt_stall;
    logic signed [COORD_IN_W-1:0] x_coord;
    logic signed [COORD_IN_W-1:0] y_coord;
    logic                         last_point;
    logic                         res_valid;
    logic                         res_stall;
    logic [OUT_SQ_W-1:0]          min_sq_distance;
    logic [OUT_FIX_W-1:0]         min_distance_fixed;
    logic                         no_pair;
    logic                         dropped_points;

    int     fail_count;
    int     pending_count;
    int     result_count;
    int     lone_sets;
    int     overflow_sets;
    int     points_sent;
    int     sets_sent;
    int     burst_left;
    longint cycle_count;

    closest_pair_distance_core #(
        .MAX_POINTS (MAX_PTS),
        .COORD_BITS (CRD_BITS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .pt_valid           (pt_valid),
        .pt_stall           (pt_stall),
        .x_coord            (x_coord),
        .y_coord            (y_coord),
        .last_point         (last_point),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .min_sq_distance    (min_sq_distance),
        .min_distance_fixed (min_distance_fixed),
        .no_pair            (no_pair),
        .dropped_points     (dropped_points)
    );

    closest_pair_distance_checker #(
        .MAX_PTS  (MAX_PTS),
        .CRD_BITS (CRD_BITS)
    ) pair_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .pt_valid           (pt_valid),
        .pt_stall           (pt_stall),
        .x_coord            (x_coord),
        .y_coord            (y_coord),
        .last_point         (last_point),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .min_sq_distance    (min_sq_distance),
        .min_distance_fixed (min_distance_fixed),
        .no_pair            (no_pair),
        .dropped_points     (dropped_points),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .result_count       (result_count),
        .lone_sets          (lone_sets),
        .overflow_sets      (overflow_sets)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run when the cycle limit runs out
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offer one point transaction; called at a falling edge, returns at one.
    // Insert a random gap between bursts, keep valid high inside a burst.
    task automatic send_point(input logic [COORD_IN_W-1:0] x,
                              input logic [COORD_IN_W-1:0] y,
                              input logic                  lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pt_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pt_valid   <= 1'b1;
        x_coord    <= x;
        y_coord    <= y;
        last_point <= lst;
        do
            @(posedge clk);
        while (pt_stall);
        @(negedge clk);
        points_sent++;
    endtask

    // Send a whole set of n_pts points, the last one closing it
    task automatic send_set(input int n_pts, input layout_t layout);
        logic [COORD_IN_W-1:0] base_x;
        logic [COORD_IN_W-1:0] base_y;
        logic [COORD_IN_W-1:0] x;
        logic [COORD_IN_W-1:0] y;
        int                    span;
        int                    k;
        base_x = COORD_IN_W'($urandom);
        base_y = COORD_IN_W'($urandom);
        span   = 1 << $urandom_range(1, 10);
        x      = base_x;
        y      = base_y;
        for (k = 0; k < n_pts; k++)
        begin
            case (layout)
                LAYOUT_CLUSTER:
                begin
                    x = base_x + COORD_IN_W'($urandom_range(0, span));
                    y = base_y + COORD_IN_W'($urandom_range(0, span));
                end
                LAYOUT_ECHO:
                begin
                    // repeat the previous point now and then
                    if (k == 0 || $urandom_range(0, 2) != 0)
                    begin
                        x = base_x + COORD_IN_W'($urandom_range(0, 255));
                        y = base_y + COORD_IN_W'($urandom_range(0, 255));
                    end
                end
                default:
                begin
                    x = COORD_IN_W'($urandom);
                    y = COORD_IN_W'($urandom);
                end
            endcase
            send_point(x, y, k == n_pts - 1);
        end
        sets_sent++;
    endtask

    // Result side: stall on changing patterns, with one long hold-off
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          tick;
        bit          held;
        res_stall = 1'b0;
        held      = 1'b0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            span = $urandom_range(20, 200);
            mode = stall_mode_t'($urandom_range(0, 3));
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (!held && result_count >= HOLD_OFF_AFTER)
                begin
                    // hold off long enough for the block to back up its input
                    res_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                    held = 1'b1;
                end
                else
                begin
                    case (mode)
                        STALL_NONE:     res_stall <= 1'b0;
                        STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
                        STALL_HEAVY:    res_stall <= ($urandom_range(0, 3) != 0);
                        STALL_PERIODIC: res_stall <= (tick % 3 == 0);
                        default:        res_stall <= 1'b0;
                    endcase
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int  n_pts;
        int  sel;
        bit  overran;
        rst_n       = 1'b0;
        pt_valid    = 1'b0;
        x_coord     = '0;
        y_coord     = '0;
        last_point  = 1'b0;
        burst_left  = 0;
        points_sent = 0;
        sets_sent   = 0;
        overran     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lone point at the corner of the range
        send_point(16'h8000, 16'h7fff, 1'b1);
        // opposite corners: the largest distance there is
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        // two identical points
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        // mixed signs around zero
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'hffff, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hffff, 1'b1);
        // alternating bit patterns
        send_point(16'h5555, 16'haaaa, 1'b0);
        send_point(16'haaaa, 16'h5555, 1'b0);
        send_point(16'h5554, 16'haaab, 1'b1);
        // unit step, then a diagonal step with a fractional root
        send_point(16'd100, 16'd100, 1'b0);
        send_point(16'd101, 16'd100, 1'b1);
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'h0001, 16'h0001, 1'b1);

        // Random sets, mostly small; one runs past the store
        while (points_sent < ITEM_GOAL)
        begin
            if (!overran && sets_sent >= 30)
            begin
                send_set(MAX_PTS + $urandom_range(1, 4), LAYOUT_SPREAD);
                overran = 1'b1;
            end
            else
            begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    n_pts = 1;
                else if (sel < 11)
                    n_pts = $urandom_range(2, 8);
                else if (sel < 15)
                    n_pts = $urandom_range(9, 20);
                else
                    n_pts = $urandom_range(21, 48);
                send_set(n_pts, layout_t'($urandom_range(0, 2)));
            end
        end
        pt_valid   <= 1'b0;
        last_point <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d point transactions in %0d sets, %0d results checked",
                 points_sent, sets_sent, result_count);
        $display("tb: %0d sets under two points, %0d sets overran the %0d-entry store",
                 lone_sets, overflow_sets, MAX_PTS);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
